>>> rtl/core/pnf_pkg.sv
`default_nettype none

package pnf_pkg;

	// Width of one list element and of the swap counter on the result channel.
	localparam int DataW  = 32;
	localparam int SwapW  = 6;

	// Default buffer depth in elements.
	localparam int DepthDefault = 64;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // store the accepted item, or flag it as dropped
		logic part_init;   // set up the pointers for the partition walk
		logic rd_ptr;      // read the elements under both pointers
		logic step_left;   // move the left pointer right
		logic step_right;  // move the right pointer left
		logic swap_wr1;    // write the right element at the left pointer
		logic swap_wr2;    // write the left element at the right pointer, step both
		logic emit_init;   // start the output pass at the first element
		logic emit_rd;     // read the element at the output index
		logic out_load;    // capture the read element into the output register
		logic emit_next;   // advance the output index
		logic clear_list;  // close the list: count, swaps and drop flag to zero
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic short_next;  // the list holds fewer than two elements after this item
		logic ptr_lt;      // left pointer is below right pointer
		logic left_neg;    // element at the left pointer is negative
		logic right_pos;   // element at the right pointer is positive
		logic emit_last;   // output index is on the final element
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/core/pnf_in_if.sv
`default_nettype none

interface pnf_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [pnf_pkg::DataW-1:0] value;
	logic                             last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pnf_out_if.sv
`default_nettype none

interface pnf_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [pnf_pkg::DataW-1:0] value_res;
	logic                             last_res;
	logic        [pnf_pkg::SwapW-1:0] swap_total;
	logic                             overflow;

	modport source (output valid, output value_res, output last_res, output swap_total,
		output overflow, input ready);
	modport sink (input valid, input value_res, input last_res, input swap_total,
		input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pnf_ctrl.sv
`default_nettype none

module pnf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_last,
	output logic               in_ready,
	input  wire logic          out_ready,
	output logic               out_valid,
	input  wire pnf_pkg::sts_t sts,
	output pnf_pkg::cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_LOAD = 7'b0000001,
		S_PRD  = 7'b0000010,
		S_PEV  = 7'b0000100,
		S_SWP  = 7'b0001000,
		S_ERD  = 7'b0010000,
		S_EWT  = 7'b0100000,
		S_EOUT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						if (sts.short_next) begin
							cmd.emit_init = 1'b1;
							state_d       = S_ERD;
						end else begin
							cmd.part_init = 1'b1;
							state_d       = S_PRD;
						end
					end
				end
			end
			S_PRD: begin
				cmd.rd_ptr = 1'b1;
				state_d    = S_PEV;
			end
			S_PEV: begin
				if (!sts.ptr_lt) begin
					cmd.emit_init = 1'b1;
					state_d       = S_ERD;
				end else if (sts.left_neg) begin
					cmd.step_left = 1'b1;
					state_d       = S_PRD;
				end else if (sts.right_pos) begin
					cmd.step_right = 1'b1;
					state_d        = S_PRD;
				end else begin
					cmd.swap_wr1 = 1'b1;
					state_d      = S_SWP;
				end
			end
			S_SWP: begin
				cmd.swap_wr2 = 1'b1;
				state_d      = S_PRD;
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EWT;
			end
			S_EWT: begin
				cmd.out_load = 1'b1;
				state_d      = S_EOUT;
			end
			S_EOUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.emit_last) begin
						cmd.clear_list = 1'b1;
						state_d        = S_LOAD;
					end else begin
						cmd.emit_next = 1'b1;
						state_d       = S_ERD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/pnf_datapath.sv
`default_nettype none

module pnf_datapath #(
	parameter int DEPTH = pnf_pkg::DepthDefault
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pnf_pkg::cmd_t                    cmd,
	output pnf_pkg::sts_t                         sts,
	input  wire logic signed [pnf_pkg::DataW-1:0] in_value,
	output logic signed      [pnf_pkg::DataW-1:0] value_res,
	output logic                                  last_res,
	output logic             [pnf_pkg::SwapW-1:0] swap_total,
	output logic                                  overflow
);

	localparam int AddrW = $clog2(DEPTH);
	localparam int CntW  = $clog2(DEPTH + 1);
	localparam int DataW = pnf_pkg::DataW;
	localparam int SwapW = pnf_pkg::SwapW;

	logic [DataW-1:0] list_mem_q [DEPTH];
	logic [DataW-1:0] rd_a_q;
	logic [DataW-1:0] rd_b_q;

	logic [CntW-1:0]  count_q;
	logic [AddrW-1:0] left_q;
	logic [AddrW-1:0] right_q;
	logic [AddrW-1:0] idx_q;
	logic [SwapW-1:0] swaps_q;
	logic             dropped_q;

	logic             has_room;
	logic [CntW-1:0]  count_next;
	logic [CntW-1:0]  count_m1;
	logic [CntW-1:0]  idx_p1;
	logic             wr_en;
	logic [AddrW-1:0] wr_addr;
	logic [DataW-1:0] wr_data;
	logic [AddrW-1:0] rd_a_addr;

	assign has_room   = count_q < CntW'(DEPTH);
	assign count_next = count_q + CntW'(has_room);
	assign count_m1   = count_next - CntW'(1);
	assign idx_p1     = CntW'(idx_q) + CntW'(1);

	assign sts.short_next = count_next < CntW'(2);
	assign sts.ptr_lt     = left_q < right_q;
	assign sts.left_neg   = rd_a_q[DataW-1];
	assign sts.right_pos  = !rd_b_q[DataW-1] && (rd_b_q != '0);
	assign sts.emit_last  = idx_p1 == count_q;

	// One write port: loading, then the two halves of a swap.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = right_q;
		wr_data = rd_a_q;
		if (cmd.load && has_room) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AddrW-1:0];
			wr_data = in_value;
		end else if (cmd.swap_wr1) begin
			wr_en   = 1'b1;
			wr_addr = left_q;
			wr_data = rd_b_q;
		end else if (cmd.swap_wr2) begin
			wr_en = 1'b1;
		end
	end

	assign rd_a_addr = cmd.emit_rd ? idx_q : left_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			list_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_ptr || cmd.emit_rd) begin
			rd_a_q <= list_mem_q[rd_a_addr];
		end
		if (cmd.rd_ptr) begin
			rd_b_q <= list_mem_q[right_q];
		end
		if (cmd.out_load) begin
			value_res  <= rd_a_q;
			last_res   <= sts.emit_last;
			swap_total <= swaps_q;
			overflow   <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			left_q    <= '0;
			right_q   <= '0;
			idx_q     <= '0;
			swaps_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= count_next;
				if (!has_room) begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.part_init) begin
				left_q  <= '0;
				right_q <= count_m1[AddrW-1:0];
				swaps_q <= '0;
			end
			if (cmd.step_left) begin
				left_q <= left_q + AddrW'(1);
			end
			if (cmd.step_right) begin
				right_q <= right_q - AddrW'(1);
			end
			if (cmd.swap_wr2) begin
				left_q  <= left_q + AddrW'(1);
				right_q <= right_q - AddrW'(1);
				swaps_q <= swaps_q + SwapW'(1);
			end
			if (cmd.emit_init) begin
				idx_q <= '0;
			end
			if (cmd.emit_next) begin
				idx_q <= idx_q + AddrW'(1);
			end
			if (cmd.clear_list) begin
				count_q   <= '0;
				swaps_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/partition_negatives_first.sv
// After the last item of a list is accepted the pointer walk runs, then the output pass; a
// list of one element skips the walk. Each pointer step passes through a read and an evaluate
// state, and a swap adds a write state. Loading accepts one item per cycle; one list is handled
// at a time. Each result item passes a buffer read, an output register load and a handshake.
// Reset (arst_n low, asynchronous) returns the controller to loading with an empty list;
// the buffer itself is not cleared, since only entries written for the open list are read.
`default_nettype none

// Sign partition of a list, negatives first.
//
// Items are written into an on-chip buffer in arrival order. The item flagged last closes
// the list, and the controller then walks two pointers inward over the buffer. The left
// pointer moves past negative elements and the right pointer moves past positive ones;
// zeros stop both. When both pointers stop with left below right, the two elements are
// exchanged by two writes and both pointers step inward. The buffer has one write
// port and two read ports; each pointer step passes through a read state and an evaluate state.
//
// When the walk ends the list is read out in order through an output register. Every result
// item carries the swap count of its list and a flag telling whether items arrived after
// the buffer was full; such items are dropped, but a dropped last item still closes the
// list. Lists of one element skip the walk and are emitted unchanged.
module partition_negatives_first #(
	parameter int DEPTH = pnf_pkg::DepthDefault
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pnf_in_if.sink     items,
	pnf_out_if.source  results
);

	pnf_pkg::cmd_t cmd;
	pnf_pkg::sts_t sts;

	// The controller sequences load, partition walk and output pass.
	pnf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_last   (items.last),
		.in_ready  (items.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the buffer, the pointers, the counters and the output register.
	pnf_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_value   (items.value),
		.value_res  (results.value_res),
		.last_res   (results.last_res),
		.swap_total (results.swap_total),
		.overflow   (results.overflow)
	);

endmodule

`default_nettype wire
